[rtl/dsgt_pkg.sv]
// Shared sizes and controller state encoding for the graphical degree sequence test.
// No dependencies.
`timescale 1ns / 1ps
package dsgt_pkg;
  localparam int unsigned MaxDegrees = 1024;
  localparam int unsigned DegW       = $clog2(MaxDegrees);   // degree and index bits
  localparam int unsigned CntW       = DegW + 1;             // count that can hold MaxDegrees
  localparam int unsigned SumW       = 2 * DegW + 2;         // sums and products

  typedef enum logic [13:0] {
    StIdle   = 14'b00000000000001,
    StDecide = 14'b00000000000010,
    StClr    = 14'b00000000000100,
    StHRs    = 14'b00000000001000,
    StHRt    = 14'b00000000010000,
    StHW     = 14'b00000000100000,
    StSRt    = 14'b00000001000000,
    StSLd    = 14'b00000010000000,
    StSEm    = 14'b00000100000000,
    StCRd    = 14'b00001000000000,
    StCA     = 14'b00010000000000,
    StCB     = 14'b00100000000000,
    StCC     = 14'b01000000000000,
    StFin    = 14'b10000000000000
  } state_e;
endpackage

[rtl/dsgt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dsgt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/degree_sequence_graphical_test.sv]
// Top level of the Erdos-Gallai graphical degree sequence test.
// Depends on dsgt_pkg and dsgt_ram.
`timescale 1ns / 1ps
// Usage:
// - Input channel (in_valid_i/in_ready_o): one request per degree; last_i closes
//   the sequence. Degrees are accepted back to back while the block is loading.
// - Output channel (out_valid_o/out_ready_i): one request per sequence,
//   graphical_o and overflow_o.
// - After the closing degree the block evaluates; in_ready_o stays low meanwhile.
//   Evaluation of n degrees runs in order: tally clear, histogram (one
//   read-modify-write of the tally RAM per degree), sorted write-back (read,
//   load and emit states per tally value, plus one write per degree), check (one
//   step per prefix). A sequence that fails the range, parity or overflow checks
//   goes from the decision state straight to the result.
// - The loop rate is set by the single read port of the degree and tally RAMs.
// - The result is held in an output register; loading of the next sequence
//   goes on while it waits. A finished evaluation waits for that register to
//   empty if the receiver still stalls.
// - Reset clears the counters, flags and the result valid bit; RAM contents are
//   not cleared, the tally entries in use are swept to zero per sequence.
// - More than MaxDegrees degrees give graphical 0, overflow 1.
module degree_sequence_graphical_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] degree_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        graphical_o,
  output logic        overflow_o
);
  localparam int unsigned DW = dsgt_pkg::DegW;
  localparam int unsigned CW = dsgt_pkg::CntW;
  localparam int unsigned SW = dsgt_pkg::SumW;
  localparam logic [CW-1:0] MaxCnt = CW'(dsgt_pkg::MaxDegrees);

  dsgt_pkg::state_e state_q, state_d;

  // load state
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] max_q, max_d;
  logic [SW-1:0] total_q, total_d;
  logic          big_q, big_d, par_q, par_d, ovf_q, ovf_d;
  // evaluation state
  logic [CW-1:0] n_q, n_d, i_q, i_d, pos_q, pos_d, k_q, k_d;
  logic [DW-1:0] v_q, v_d, ha_q, ha_d;
  logic [CW-1:0] cnt_q, cnt_d, lt_q, lt_d;
  logic [SW-1:0] pre_q, pre_d, slt_q, slt_d, prod_q, prod_d, kk_q, kk_d, kg_q, kg_d;
  logic          usea_q, usea_d;
  logic [SW-1:0] stot_q, stot_d;  // total of the sequence under evaluation
  // result register
  logic          rv_q, rv_d, g_q, g_d, o_q, o_d, fg_q, fg_d, fo_q, fo_d;

  // RAM ports
  logic          s_we, t_we;
  logic [DW-1:0] s_wa, s_ra, t_wa, t_ra;
  logic [DW-1:0] s_wd, s_rd;
  logic [CW-1:0] t_wd, t_rd;

  logic          acc;
  logic          d_big;
  logic [CW-1:0] g_cnt;
  logic [SW-1:0] tail;

  assign in_ready_o  = (state_q == dsgt_pkg::StIdle);
  assign acc         = in_valid_i && in_ready_o;
  assign d_big       = ({1'b0, degree_i} >= 17'(dsgt_pkg::MaxDegrees));
  assign out_valid_o = rv_q;
  assign graphical_o = g_q;
  assign overflow_o  = o_q;
  assign g_cnt       = n_q - lt_q;
  assign tail        = usea_q ? (kg_q + slt_q) : (stot_q - pre_q);

  dsgt_ram #(.Width(DW), .Depth(dsgt_pkg::MaxDegrees)) u_store (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );
  dsgt_ram #(.Width(CW), .Depth(dsgt_pkg::MaxDegrees)) u_tally (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q; max_d = max_q; total_d = total_q;
    big_d = big_q; par_d = par_q; ovf_d = ovf_q;
    n_d = n_q; i_d = i_q; pos_d = pos_q; k_d = k_q; v_d = v_q; ha_d = ha_q;
    cnt_d = cnt_q; lt_d = lt_q; pre_d = pre_q; slt_d = slt_q; prod_d = prod_q;
    kk_d = kk_q; kg_d = kg_q; usea_d = usea_q; stot_d = stot_q;
    rv_d = rv_q; g_d = g_q; o_d = o_q; fg_d = fg_q; fo_d = fo_q;
    s_we = 1'b0; s_wa = count_q[DW-1:0]; s_wd = '0; s_ra = i_q[DW-1:0];
    t_we = 1'b0; t_wa = i_q[DW-1:0];     t_wd = '0; t_ra = s_rd;

    if (rv_q && out_ready_i) begin
      rv_d = 1'b0;
    end

    case (state_q)
      dsgt_pkg::StIdle: begin
        if (acc) begin
          par_d = par_q ^ degree_i[0];
          if (count_q < MaxCnt) begin
            s_we    = 1'b1;
            count_d = count_q + CW'(1);
            if (d_big) begin
              big_d = 1'b1;
            end else begin
              s_wd    = degree_i[DW-1:0];
              total_d = total_q + SW'(degree_i[DW-1:0]);
              if (degree_i[DW-1:0] > max_q) begin
                max_d = degree_i[DW-1:0];
              end
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            // snapshot the sequence and clear the load state
            n_d = count_d; stot_d = total_d;
            fo_d = ovf_d;
            fg_d = !(ovf_d || big_d || par_d || ({1'b0, max_d} >= count_d));
            count_d = '0; max_d = '0; total_d = '0;
            big_d = 1'b0; par_d = 1'b0; ovf_d = 1'b0;
            state_d = dsgt_pkg::StDecide;
          end
        end
      end
      dsgt_pkg::StDecide: begin
        i_d = '0;
        state_d = fg_q ? dsgt_pkg::StClr : dsgt_pkg::StFin;
      end
      dsgt_pkg::StClr: begin
        t_we = 1'b1;
        if (i_q == n_q - CW'(1)) begin
          i_d = '0;
          state_d = dsgt_pkg::StHRs;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      dsgt_pkg::StHRs: begin
        state_d = dsgt_pkg::StHRt;
      end
      dsgt_pkg::StHRt: begin
        ha_d = s_rd;
        state_d = dsgt_pkg::StHW;
      end
      dsgt_pkg::StHW: begin
        t_we = 1'b1; t_wa = ha_q; t_wd = t_rd + CW'(1);
        if (i_q == n_q - CW'(1)) begin
          v_d = DW'(n_q - CW'(1));
          pos_d = '0;
          state_d = dsgt_pkg::StSRt;
        end else begin
          i_d = i_q + CW'(1);
          state_d = dsgt_pkg::StHRs;
        end
      end
      dsgt_pkg::StSRt: begin
        t_ra = v_q;
        state_d = dsgt_pkg::StSLd;
      end
      dsgt_pkg::StSLd: begin
        cnt_d = t_rd;
        state_d = dsgt_pkg::StSEm;
      end
      dsgt_pkg::StSEm: begin
        // write the tally back out as a descending sequence
        if (cnt_q == '0) begin
          if (v_q == '0) begin
            k_d = CW'(1); pre_d = '0; lt_d = '0; slt_d = '0;
            state_d = dsgt_pkg::StCRd;
          end else begin
            v_d = v_q - DW'(1);
            state_d = dsgt_pkg::StSRt;
          end
        end else begin
          s_we = 1'b1; s_wa = pos_q[DW-1:0]; s_wd = v_q;
          pos_d = pos_q + CW'(1);
          cnt_d = cnt_q - CW'(1);
        end
      end
      dsgt_pkg::StCRd: begin
        s_ra = DW'(k_q - CW'(1));
        t_ra = DW'(k_q - CW'(1));
        state_d = dsgt_pkg::StCA;
      end
      dsgt_pkg::StCA: begin
        pre_d  = pre_q + SW'(s_rd);
        lt_d   = lt_q + t_rd;
        prod_d = SW'(k_q - CW'(1)) * SW'(t_rd);
        kk_d   = SW'(k_q) * SW'(k_q - CW'(1));
        state_d = dsgt_pkg::StCB;
      end
      dsgt_pkg::StCB: begin
        // lt_q: degrees below k; slt gets their sum
        slt_d  = slt_q + prod_q;
        usea_d = (g_cnt >= k_q);
        kg_d   = SW'(k_q) * SW'(g_cnt - k_q);
        state_d = dsgt_pkg::StCC;
      end
      dsgt_pkg::StCC: begin
        if (pre_q > kk_q + tail) begin
          fg_d = 1'b0;
          state_d = dsgt_pkg::StFin;
        end else if (k_q == n_q) begin
          state_d = dsgt_pkg::StFin;
        end else begin
          k_d = k_q + CW'(1);
          state_d = dsgt_pkg::StCRd;
        end
      end
      dsgt_pkg::StFin: begin
        if (!rv_q) begin
          rv_d = 1'b1; g_d = fg_q; o_d = fo_q;
          state_d = dsgt_pkg::StIdle;
        end
      end
      default: begin
        state_d = dsgt_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsgt_pkg::StIdle;
      count_q <= '0; max_q <= '0; total_q <= '0;
      big_q <= 1'b0; par_q <= 1'b0; ovf_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d; max_q <= max_d; total_q <= total_d;
      big_q <= big_d; par_q <= par_d; ovf_q <= ovf_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; pos_q <= pos_d; k_q <= k_d; v_q <= v_d; ha_q <= ha_d;
    cnt_q <= cnt_d; lt_q <= lt_d; pre_q <= pre_d; slt_q <= slt_d; prod_q <= prod_d;
    kk_q <= kk_d; kg_q <= kg_d; usea_q <= usea_d; stot_q <= stot_d;
    g_q <= g_d; o_q <= o_d; fg_q <= fg_d; fo_q <= fo_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("item count past store depth");
  a_ovf_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && last_i && (ovf_q || count_q == MaxCnt)) |=> (state_q == dsgt_pkg::StDecide && fo_q))
    else $error("overflow sequence not flagged");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsgt_pkg::StCC) |-> (k_q >= CW'(1) && k_q <= n_q))
    else $error("check index out of range");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsgt_pkg::StSEm && cnt_q != '0) |-> (pos_q < n_q))
    else $error("sorted write past sequence end");
endmodule

[bench/degree_sequence_graphical_test_tb.sv]
// Testbench for degree_sequence_graphical_test: drives degree sequences, predicts
// the Erdos-Gallai verdict in a behavioral model and checks each result request.
// Depends on dsgt_pkg and the RTL top level.
`timescale 1ns / 1ps
module degree_sequence_graphical_test_tb;

  localparam int ClkHalf = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] degree_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        graphical_o;
  logic        overflow_o;

  always #ClkHalf clk_i = ~clk_i;

  degree_sequence_graphical_test u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .degree_i   (degree_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .graphical_o(graphical_o),
    .overflow_o (overflow_o)
  );

  typedef struct packed {
    logic graphical;
    logic overflow;
  } verdict_t;

  // Predictor state: degrees of the open sequence and its flags.
  int unsigned seq_deg[$];
  bit          big_seen;
  bit          odd_sum;
  bit          store_full;
  verdict_t    verdict_q[$];
  int          fail_cnt = 0;
  bit          quiet = 1'b0;   // no idling in the final stretch

  // Erdos-Gallai on the held degrees; brute-force tail sum, not the tally prefix counts.
  function automatic bit eg_holds(int unsigned d[$]);
    int unsigned n;
    int unsigned srt[$];
    longint      lhs, rhs;
    n = d.size();
    if (n == 0) return 1'b0;
    foreach (d[i]) if (d[i] >= n) return 1'b0;
    srt = d;
    srt.rsort();
    lhs = 0;
    for (int k = 1; k <= n; k++) begin
      lhs += srt[k-1];
      rhs = longint'(k) * (k - 1);
      for (int i = k; i < n; i++) rhs += (srt[i] < k) ? srt[i] : k;
      if (lhs > rhs) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Fold one accepted degree into the predictor; closing degree queues a verdict.
  function automatic void take_degree(logic [15:0] d, logic lst);
    verdict_t v;
    if (seq_deg.size() < dsgt_pkg::MaxDegrees) begin
      if (d >= dsgt_pkg::MaxDegrees) begin
        big_seen = 1'b1;
        seq_deg = {seq_deg, 32'd0};
      end else begin
        seq_deg = {seq_deg, 32'(d)};
      end
    end else begin
      store_full = 1'b1;
    end
    odd_sum ^= d[0];
    if (lst) begin
      if (store_full) v = '{graphical: 1'b0, overflow: 1'b1};
      else v = '{graphical: !big_seen && !odd_sum && eg_holds(seq_deg), overflow: 1'b0};
      verdict_q = {verdict_q, v};
      seq_deg.delete();
      big_seen = 1'b0;
      odd_sum = 1'b0;
      store_full = 1'b0;
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && in_valid_i && in_ready_o) take_degree(degree_i, last_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $error("result request with nothing expected");
        fail_cnt++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (graphical_o !== exp_v.graphical) begin
          $error("graphical: expected %0b actual %0b", exp_v.graphical, graphical_o);
          fail_cnt++;
        end
        if (overflow_o !== exp_v.overflow) begin
          $error("overflow: expected %0b actual %0b", exp_v.overflow, overflow_o);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver: random stall bursts, none in the last part.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Send one request and hold it until accepted; may idle first.
  task automatic push_degree(logic [15:0] d, logic lst);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    degree_i   <= d;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Directed rows: degree, closing flag. Expected verdict typed only where obvious.
  typedef struct {
    logic [15:0] deg;
    logic        lst;
  } row_t;
  row_t dir_rows[] = '{
    '{16'd0, 1'b1},                                  // single zero: graphical
    '{16'd1, 1'b1},                                  // single nonzero: not
    '{16'hFFFF, 1'b0}, '{16'd0, 1'b1},               // huge degree
    '{16'd1024, 1'b0}, '{16'd0, 1'b1},               // degree at store size
    '{16'd1, 1'b0}, '{16'd1, 1'b1},                  // single edge
    '{16'd1, 1'b0}, '{16'd0, 1'b1},                  // odd sum
    '{16'd2, 1'b0}, '{16'd2, 1'b0}, '{16'd2, 1'b1},  // triangle
    '{16'd3, 1'b0}, '{16'd3, 1'b0}, '{16'd1, 1'b0}, '{16'd1, 1'b1}, // EG violation
    '{16'd2, 1'b0}, '{16'd2, 1'b1}                   // degree equals n
  };
  // Hand-read verdicts per sequence in table order.
  verdict_t dir_exp[] = '{
    '{1'b1, 1'b0}, '{1'b0, 1'b0}, '{1'b0, 1'b0}, '{1'b0, 1'b0}, '{1'b1, 1'b0},
    '{1'b0, 1'b0}, '{1'b1, 1'b0}, '{1'b0, 1'b0}, '{1'b0, 1'b0}
  };

  // Random sequence: in half the draws degrees from random edges, else random noise.
  task automatic send_random_seq(int unsigned len);
    int unsigned d[$];
    int unsigned a, b, m;
    d = {};
    repeat (len) d = {d, 32'd0};
    case ($urandom_range(0, 3))
      0, 1: begin
        // random edges between distinct nodes; repeats allowed, so not always realizable
        m = $urandom_range(0, len * 2);
        repeat (m) begin
          a = $urandom_range(0, len - 1);
          b = $urandom_range(0, len - 1);
          if (a != b) begin d[a]++; d[b]++; end
        end
        if (len > 1 && $urandom_range(0, 2) == 0) d[$urandom_range(0, len - 1)] ^= 1;
      end
      2: foreach (d[i]) d[i] = $urandom_range(0, len);
      default: foreach (d[i]) d[i] = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
    endcase
    foreach (d[i]) push_degree(d[i][15:0], i == len - 1);
  endtask

  task automatic drain;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned seq_no;
    int unsigned n;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: check the typed-in verdicts against the predictor's view.
    seq_no = 0;
    foreach (dir_rows[i]) begin
      push_degree(dir_rows[i].deg, dir_rows[i].lst);
      if (dir_rows[i].lst) begin
        if (verdict_q[$] != dir_exp[seq_no]) begin
          $error("directed row %0d: table and predictor disagree", i);
          fail_cnt++;
        end
        seq_no++;
      end
    end
    in_valid_i <= 1'b0;
    drain();   // sender pauses until every result is back

    // Store overflow: one degree more than the store holds.
    for (int i = 0; i <= dsgt_pkg::MaxDegrees; i++) begin
      push_degree(16'(i % 3), i == dsgt_pkg::MaxDegrees);
    end

    sent = 0;
    while (sent < 300) begin
      if (sent > 200) quiet = 1'b1;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 9);
      send_random_seq(n);
      sent += n;
    end
    in_valid_i <= 1'b0;
    drain();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
